[rtl/gppr_pkg.sv]
// Shared types and constants for the gamepad pointer report mapper.
// No dependencies; used by every module of the block.
package gppr_pkg;

	// Table geometry
	localparam int TABLE_SLOTS      = 16;
	localparam int MAX_MAP_ENTRIES  = 16;
	localparam int SRC_W            = 5;
	localparam int DST_W            = 4;

	// Register indexes of the configuration channel
	localparam logic [2:0] REG_MAP_COUNT   = 3'd0;
	localparam logic [2:0] REG_SRC_LOW     = 3'd1;
	localparam logic [2:0] REG_SRC_HIGH    = 3'd2;
	localparam logic [2:0] REG_TARGETS     = 3'd3;
	localparam logic [2:0] REG_TOGGLE_BTN  = 3'd4;
	localparam logic [2:0] REG_VELOCITY    = 3'd5;

	// Pointer geometry
	localparam int AXIS_FULL_SCALE = 1140;
	localparam int PTR_CENTER_X    = 512;
	localparam int PTR_CENTER_Y    = 384;
	localparam int PTR_MAX         = 1023;

	// Reciprocal of full scale: ceil(2^30 / 1140). Exact floor division for
	// products below 2^20 because (R*1140 - 2^30) * 2^20 < 2^30.
	localparam int RECIP_SHIFT = 30;
	localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + AXIS_FULL_SCALE - 1) / AXIS_FULL_SCALE;
	localparam int VEL_R_W     = 28;

	localparam logic [4:0] RESET_MAP_COUNT = 5'd13;
	localparam logic [7:0] RESET_VELOCITY  = 8'd50;

	// Active configuration as seen by the datapath
	typedef struct packed {
		logic [4:0]                          map_count;
		logic [TABLE_SLOTS*SRC_W-1:0]        sources;   // entry i at 5i+4:5i
		logic [TABLE_SLOTS*DST_W-1:0]        targets;   // entry i at 4i+3:4i
		logic [4:0]                          toggle_btn;
		logic [VEL_R_W-1:0]                  vel_r;     // velocity * RECIP
	} cfg_t;

endpackage

[rtl/gppr_cfg_regs.sv]
// Configuration register file of the pointer report mapper.
// Depends on gppr_pkg for register indexes, reset values and cfg_t.
module gppr_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [63:0]        wr_data,
	output gppr_pkg::cfg_t     cfg
);

	localparam int SRC_HALF = gppr_pkg::TABLE_SLOTS * gppr_pkg::SRC_W / 2;

	logic [4:0]                    count_q;
	logic [SRC_HALF-1:0]           src_lo_q;
	logic [SRC_HALF-1:0]           src_hi_q;
	logic [63:0]                   targets_q;
	logic [4:0]                    toggle_q;
	logic [gppr_pkg::VEL_R_W-1:0]  vel_r_q;
	logic [gppr_pkg::VEL_R_W-1:0]  vel_r_next;
	logic [gppr_pkg::VEL_R_W-1:0]  vel_r_reset;

	// velocity is kept premultiplied by the reciprocal of full scale
	assign vel_r_next  = gppr_pkg::VEL_R_W'(wr_data[7:0] * gppr_pkg::VEL_R_W'(gppr_pkg::RECIP));
	assign vel_r_reset = gppr_pkg::VEL_R_W'(gppr_pkg::RESET_VELOCITY * gppr_pkg::RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= gppr_pkg::RESET_MAP_COUNT;
			src_lo_q  <= '0;
			src_hi_q  <= '0;
			targets_q <= '0;
			toggle_q  <= '0;
			vel_r_q   <= vel_r_reset;
		end else if (wr_en) begin
			case (wr_index)
				gppr_pkg::REG_MAP_COUNT:  count_q   <= wr_data[4:0];
				gppr_pkg::REG_SRC_LOW:    src_lo_q  <= wr_data[SRC_HALF-1:0];
				gppr_pkg::REG_SRC_HIGH:   src_hi_q  <= wr_data[SRC_HALF-1:0];
				gppr_pkg::REG_TARGETS:    targets_q <= wr_data;
				gppr_pkg::REG_TOGGLE_BTN: toggle_q  <= wr_data[4:0];
				gppr_pkg::REG_VELOCITY:   vel_r_q   <= vel_r_next;
				default: ;
			endcase
		end
	end

	assign cfg.map_count  = count_q;
	assign cfg.sources    = {src_hi_q, src_lo_q};
	assign cfg.targets    = targets_q;
	assign cfg.toggle_btn = toggle_q;
	assign cfg.vel_r      = vel_r_q;

endmodule

[rtl/gppr_btn_map.sv]
// Button remap: ORs selected source buttons into the 16-bit core word.
// Depends on gppr_pkg for table geometry and cfg_t.
module gppr_btn_map #(
	parameter int MAX_MAP_ENTRIES = gppr_pkg::MAX_MAP_ENTRIES
) (
	input  logic [31:0]        buttons,
	input  gppr_pkg::cfg_t     cfg,
	output logic [15:0]        core
);

	// slots that exist in hardware
	localparam int SLOTS = (MAX_MAP_ENTRIES < gppr_pkg::TABLE_SLOTS) ?
		MAX_MAP_ENTRIES : gppr_pkg::TABLE_SLOTS;

	always_comb begin
		logic [gppr_pkg::SRC_W-1:0] src;
		logic [gppr_pkg::DST_W-1:0] dst;
		core = '0;
		for (int i = 0; i < SLOTS; i++) begin
			src = cfg.sources[i*gppr_pkg::SRC_W +: gppr_pkg::SRC_W];
			dst = cfg.targets[i*gppr_pkg::DST_W +: gppr_pkg::DST_W];
			// count above SLOTS saturates naturally
			if ((5'(i) < cfg.map_count) && buttons[src])
				core[dst] = 1'b1;
		end
	end

endmodule

[rtl/gppr_ptr_scale.sv]
// Pointer scaling: center +/- stick*velocity/1140 (truncating), clamped 0..1023.
// Depends on gppr_pkg for pointer geometry and the reciprocal constant.
module gppr_ptr_scale (
	input  logic signed [11:0]             stick_x,
	input  logic signed [11:0]             stick_y,
	input  logic [gppr_pkg::VEL_R_W-1:0]   vel_r,
	output logic [9:0]                     ptr_x,
	output logic [9:0]                     ptr_y
);

	localparam int PROD_W = 12 + gppr_pkg::VEL_R_W;

	// |stick| * vel * R >> 30 == floor(|stick|*vel / 1140)
	function automatic logic [9:0] quot(input logic signed [11:0] s,
	                                    input logic [gppr_pkg::VEL_R_W-1:0] vr);
		logic [11:0]       mag;
		logic [PROD_W-1:0] prod;
		mag  = s[11] ? 12'(-s) : 12'(s);
		prod = PROD_W'(mag) * PROD_W'(vr);
		return prod[gppr_pkg::RECIP_SHIFT +: 10];
	endfunction

	function automatic logic [9:0] clamp(input logic signed [12:0] v);
		if (v < 0)
			return '0;
		else if (v > 13'(gppr_pkg::PTR_MAX))
			return 10'(gppr_pkg::PTR_MAX);
		else
			return v[9:0];
	endfunction

	logic [9:0]         qx;
	logic [9:0]         qy;
	logic signed [12:0] vx;
	logic signed [12:0] vy;

	assign qx = quot(stick_x, vel_r);
	assign qy = quot(stick_y, vel_r);

	// Y is inverted: up positive on the stick is smaller Y on screen
	assign vx = stick_x[11] ? 13'(gppr_pkg::PTR_CENTER_X) - 13'(qx)
	                        : 13'(gppr_pkg::PTR_CENTER_X) + 13'(qx);
	assign vy = stick_y[11] ? 13'(gppr_pkg::PTR_CENTER_Y) + 13'(qy)
	                        : 13'(gppr_pkg::PTR_CENTER_Y) - 13'(qy);

	assign ptr_x = clamp(vx);
	assign ptr_y = clamp(vy);

endmodule

[rtl/gamepad_pointer_report_mapper.sv]
// Top level of the gamepad pointer report mapper: pipeline, toggle state, ports.
// Depends on gppr_pkg, gppr_cfg_regs, gppr_btn_map and gppr_ptr_scale.
//
// Usage:
//   Slave stream (s_*) takes one normalized gamepad sample per transaction.
//   Master stream (m_*) gives one report per sample, in order.
//   The configuration channel (cfg_*) writes one register per transaction;
//   cfg_ready is always high. Indexes above the register list are ignored.
//   Write configuration only while no sample is in flight.
// Pipeline and throughput:
//   Two register stages: an accepted sample is captured in the input register,
//   then moves to the result register, which drives m_*, when that register is
//   free. One sample per cycle is sustained while m_tready stays high; the
//   mapping, scaling and clamp are all single-pass logic between the two
//   registers, with one 12x28 multiplier per axis.
// Stall:
//   When m_tready is low the result register holds; the input register
//   still fills, and s_tready drops only when both stages are occupied.
// Reset:
//   arst_n clears both stages, the toggle edge detector and pointer mode
//   (pointer off). Registers return to count 13, all sources and targets 0,
//   toggle button 0, velocity 50.
// Pointer mode flips on the rising edge of the toggle button, judged
// sample to sample as samples leave the input stage.
module gamepad_pointer_report_mapper #(
	parameter int MAX_MAP_ENTRIES = gppr_pkg::MAX_MAP_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // pro_buttons[31:0], stick_x[43:32], stick_y[55:44]
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // btn_word[15:0], dot_x_low[23:16],
	                               // dot_y_low[31:24], dot_high_bits[39:32]
	output logic [0:0]  m_tuser,   // report_kind[0]
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	gppr_pkg::cfg_t cfg;

	// input stage
	logic               valid_s1;
	logic [31:0]        buttons_s1;
	logic signed [11:0] sx_s1;
	logic signed [11:0] sy_s1;

	// result stage
	logic               valid_s2;
	logic               kind_s2;
	logic [15:0]        core_s2;
	logic [7:0]         xlo_s2;
	logic [7:0]         ylo_s2;
	logic [7:0]         hi_s2;

	// pointer mode state
	logic               was_pressed_q;
	logic               active_q;

	logic               adv;
	logic               tog;
	logic               active_next;
	logic [15:0]        core;
	logic [9:0]         ptr_x;
	logic [9:0]         ptr_y;

	assign cfg_ready = 1'b1;

	gppr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	gppr_btn_map #(
		.MAX_MAP_ENTRIES (MAX_MAP_ENTRIES)
	) u_btn (
		.buttons (buttons_s1),
		.cfg     (cfg),
		.core    (core)
	);

	gppr_ptr_scale u_ptr (
		.stick_x (sx_s1),
		.stick_y (sy_s1),
		.vel_r   (cfg.vel_r),
		.ptr_x   (ptr_x),
		.ptr_y   (ptr_y)
	);

	// stage 1 moves forward whenever the result register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	assign tog         = buttons_s1[cfg.toggle_btn];
	assign active_next = active_q ^ (tog && !was_pressed_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			buttons_s1 <= s_tdata[31:0];
			sx_s1      <= s_tdata[43:32];
			sy_s1      <= s_tdata[55:44];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			was_pressed_q <= 1'b0;
			active_q      <= 1'b0;
		end else if (adv) begin
			valid_s2      <= 1'b1;
			was_pressed_q <= tog;
			active_q      <= active_next;
		end else if (m_tready) begin
			valid_s2      <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= active_next;
			core_s2 <= core;
			if (active_next) begin
				xlo_s2 <= ptr_x[7:0];
				ylo_s2 <= ptr_y[7:0];
				hi_s2  <= {ptr_x[9:8], ptr_y[9:8], 4'hF};
			end else begin
				xlo_s2 <= '0;
				ylo_s2 <= '0;
				hi_s2  <= '0;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {hi_s2, ylo_s2, xlo_s2, core_s2};
	assign m_tuser  = kind_s2;

`ifndef SYNTHESIS
	// buttons-only report carries an all-zero dot
	a_kind0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[39:16] == 24'd0)
		else $error("buttons-only report with nonzero dot fields");

	// dot report always carries the 0xF marker nibble
	a_kind1_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[35:32] == 4'hF)
		else $error("dot report without marker nibble");

	// empty result stage never blocks the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with empty result stage");

	// rising toggle edge flips pointer mode
	a_toggle_flip: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tog && !was_pressed_q |=> active_q != $past(active_q))
		else $error("pointer mode did not flip on toggle edge");

	// pointer mode changes only when a sample passes stage 1
	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(active_q))
		else $error("pointer mode changed without a sample");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for gamepad_pointer_report_mapper: random-gap stream driver,
// checking monitor and an in-order report predictor.
// Depends on gppr_pkg and the RTL top level only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES     = 11;
	localparam int CYCLE_LIMIT      = 1000000;
	localparam int HOLD_CYCLES      = 400;  // long receiver hold-off, fills both stages
	localparam int TAIL_CYCLES      = 8;    // two register stages plus margin
	localparam int RANDOM_PHASES    = 8;
	localparam int PHASE_SAMPLES    = 200;
	localparam int ENTRIES_PER_WORD = 8;    // source indexes per source register

	// Indexes past the register list; writes there must leave the block alone
	localparam logic [2:0] REG_NONE_LO = 3'd6;
	localparam logic [2:0] REG_NONE_HI = 3'd7;

	// One gamepad sample, laid out exactly as s_tdata
	typedef struct packed {
		logic signed [11:0] stick_y;
		logic signed [11:0] stick_x;
		logic [31:0]        buttons;
	} sample_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] core;
		logic [7:0]  x_low;
		logic [7:0]  y_low;
		logic [7:0]  high_bits;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	gamepad_pointer_report_mapper u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state: shadow of the registers plus the toggle detector.
	// Registers only change while the block is drained, so the shadow
	// is always the setting every in-flight sample sees.
	// ------------------------------------------------------------------
	logic [4:0]  map_count_r  = gppr_pkg::RESET_MAP_COUNT;
	logic [39:0] src_low_r    = '0;
	logic [39:0] src_high_r   = '0;
	logic [63:0] targets_r    = '0;
	logic [4:0]  toggle_btn_r = '0;
	logic [7:0]  velocity_r   = gppr_pkg::RESET_VELOCITY;
	logic        toggle_held  = 1'b0;
	logic        pointer_on   = 1'b0;

	sample_t     pending_samples[$];
	report_t     expected_reports[$];
	int          fail_count = 0;
	int          hold_asks = 0;   // bumped by the stimulus, served by the hold counter

	function automatic int clamp_ptr(int v);
		if (v < 0)
			return 0;
		if (v > gppr_pkg::PTR_MAX)
			return gppr_pkg::PTR_MAX;
		return v;
	endfunction

	// Next report for one sample; advances the pointer-mode state
	function automatic report_t predict_report(sample_t s);
		report_t     r;
		logic [15:0] word;
		logic [4:0]  src;
		logic [3:0]  dst;
		logic        tog;
		int          n;
		int          px;
		int          py;
		word = '0;
		n = (int'(map_count_r) > gppr_pkg::MAX_MAP_ENTRIES) ? gppr_pkg::MAX_MAP_ENTRIES
		                                                     : int'(map_count_r);
		if (n > gppr_pkg::TABLE_SLOTS)
			n = gppr_pkg::TABLE_SLOTS;
		for (int i = 0; i < n; i++) begin
			src = (i < ENTRIES_PER_WORD)
			    ? src_low_r[gppr_pkg::SRC_W*(i%ENTRIES_PER_WORD) +: gppr_pkg::SRC_W]
			    : src_high_r[gppr_pkg::SRC_W*(i%ENTRIES_PER_WORD) +: gppr_pkg::SRC_W];
			dst = targets_r[gppr_pkg::DST_W*i +: gppr_pkg::DST_W];
			if (s.buttons[src])
				word[dst] = 1'b1;
		end

		tog = s.buttons[toggle_btn_r];
		if (tog && !toggle_held)
			pointer_on = !pointer_on;
		toggle_held = tog;

		r = '0;
		r.core = word;
		if (pointer_on) begin
			// C-style division: truncates toward zero for negative products
			px = clamp_ptr(gppr_pkg::PTR_CENTER_X
			               + ($signed(s.stick_x) * int'(velocity_r))
			                 / gppr_pkg::AXIS_FULL_SCALE);
			py = clamp_ptr(gppr_pkg::PTR_CENTER_Y
			               - ($signed(s.stick_y) * int'(velocity_r))
			                 / gppr_pkg::AXIS_FULL_SCALE);
			r.kind      = 1'b1;
			r.x_low     = px[7:0];
			r.y_low     = py[7:0];
			r.high_bits = {px[9:8], py[9:8], 4'hF};
		end
		return r;
	endfunction

	// Gap length for either side: mostly none or short, a few long, and
	// now and then a streak of back-to-back transactions
	function automatic int unsigned idle_len(inout int unsigned streak);
		int unsigned r;
		if (streak != 0) begin
			streak--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			streak = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Driver: one sample per transaction; valid holds until accepted.
	// The expectation is formed at the accepting edge, in stream order.
	// ------------------------------------------------------------------
	sample_t     cur_sample;
	int unsigned send_gap = 0;
	int unsigned send_streak = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_reports.push_back(predict_report(cur_sample));
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					cur_sample = pending_samples.pop_front();
					s_tdata  <= cur_sample;
					s_tvalid <= 1'b1;
					send_gap = idle_len(send_streak);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Long receiver hold-off, counted in cycles on request
	// ------------------------------------------------------------------
	int unsigned hold_left = 0;
	int          hold_done = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random back-pressure, the long hold-off, and a
	// field-by-field compare of every report with the oldest expectation.
	// ------------------------------------------------------------------
	int unsigned recv_gap = 0;
	int unsigned recv_streak = 0;
	report_t     want;

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
			         $time, name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: report with no expectation waiting, actual tdata 0x%0h",
					         $time, m_tdata);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("report_kind",   want.kind,      m_tuser[0]);
					check_field("btn_word",      want.core,      m_tdata[15:0]);
					check_field("dot_x_low",     want.x_low,     m_tdata[23:16]);
					check_field("dot_y_low",     want.y_low,     m_tdata[31:24]);
					check_field("dot_high_bits", want.high_bits, m_tdata[39:32]);
				end
				recv_gap = idle_len(recv_streak);
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d reports outstanding",
			         $time, cycle_count, expected_reports.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// One register write; the shadow follows at the accepting edge.
	// Ends on a falling edge so callers queue samples at a quiet point.
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			gppr_pkg::REG_MAP_COUNT:  map_count_r  = val[4:0];
			gppr_pkg::REG_SRC_LOW:    src_low_r    = val[39:0];
			gppr_pkg::REG_SRC_HIGH:   src_high_r   = val[39:0];
			gppr_pkg::REG_TARGETS:    targets_r    = val;
			gppr_pkg::REG_TOGGLE_BTN: toggle_btn_r = val[4:0];
			gppr_pkg::REG_VELOCITY:   velocity_r   = val[7:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic queue_sample(logic [31:0] btn, logic signed [11:0] sx,
	                            logic signed [11:0] sy);
		sample_t s;
		s.buttons = btn;
		s.stick_x = sx;
		s.stick_y = sy;
		pending_samples.push_back(s);
	endtask

	// Block until every queued sample has gone in and its report come out
	task automatic drain();
		do @(negedge clk);
		while (pending_samples.size() != 0 || s_tvalid || expected_reports.size() != 0);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic signed [11:0] rand_stick();
		logic signed [11:0] v;
		case ($urandom_range(0, 9))
			0: v = 12'($urandom());  // anywhere in 12 bits, clamp territory
			1: v = 12'sd2047;
			2: v = -12'sd2048;
			3: v = ($urandom_range(0, 1) != 0) ? 12'sd1140 : -12'sd1140;
			4: v = 12'($urandom_range(0, 2) - 1);
			default: v = 12'($urandom_range(0, 2280) - 1140);
		endcase
		return v;
	endfunction

	// New random setting; the fixed picks land on the limits of the count and velocity registers
	task automatic program_random_setup();
		logic [63:0] v;
		v = rand64();
		case ($urandom_range(0, 6))
			0: v[4:0] = 5'd0;
			1: v[4:0] = 5'd16;
			2: v[4:0] = 5'd17;
			3: v[4:0] = 5'd31;
			4: v[4:0] = 5'd1;
			default: ;
		endcase
		write_reg(gppr_pkg::REG_MAP_COUNT, v);
		write_reg(gppr_pkg::REG_SRC_LOW, rand64());
		write_reg(gppr_pkg::REG_SRC_HIGH, rand64());
		write_reg(gppr_pkg::REG_TARGETS, rand64());
		write_reg(gppr_pkg::REG_TOGGLE_BTN, rand64());
		v = rand64();
		case ($urandom_range(0, 5))
			0: v[7:0] = 8'd0;
			1: v[7:0] = 8'd255;
			2: v[7:0] = 8'd1;
			default: ;
		endcase
		write_reg(gppr_pkg::REG_VELOCITY, v);
		if ($urandom_range(0, 1) != 0)
			write_reg(($urandom_range(0, 1) != 0) ? REG_NONE_HI : REG_NONE_LO, rand64());
	endtask

	initial begin
		logic [31:0] btn;
		logic        held;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset table: 13 entries all map button 0 to core bit 0, button 0
		// toggles the pointer, velocity 50
		queue_sample(32'h0000_0000, 12'sd0, 12'sd0);
		queue_sample(32'hFFFF_FFFE, 12'sd1140, -12'sd1140);
		queue_sample(32'h0000_0001, 12'sd2047, -12'sd2048);
		queue_sample(32'h0000_0001, -12'sd2048, 12'sd2047);
		queue_sample(32'h0000_0000, 12'sd1140, 12'sd1140);
		queue_sample(32'hFFFF_FFFF, 12'sd0, 12'sd0);
		drain();

		// Full table, top button as toggle, top velocity; stray writes ignored
		write_reg(gppr_pkg::REG_MAP_COUNT, 64'd16);
		write_reg(gppr_pkg::REG_SRC_LOW, 64'hFFFF_FF00_0000_0000 | 64'hFF_FFFF_FFFF);
		write_reg(gppr_pkg::REG_SRC_HIGH, 64'h0000_0000_0000_0000);
		write_reg(gppr_pkg::REG_TARGETS, 64'hFEDC_BA98_7654_3210);
		write_reg(gppr_pkg::REG_TOGGLE_BTN, 64'd31);
		write_reg(gppr_pkg::REG_VELOCITY, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_NONE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_NONE_HI, 64'h0);
		queue_sample(32'h8000_0000, -12'sd1140, 12'sd1140);
		queue_sample(32'h8000_0000, -12'sd2048, 12'sd2047);   // pointer still off, dot fields zero
		queue_sample(32'h0000_0000, 12'sd2047, -12'sd2048);
		queue_sample(32'h0000_0001, -12'sd5, 12'sd5);         // pointer mode still off, so the dot fields are zero
		queue_sample(32'h8000_0000, 12'sd1, -12'sd1);         // toggles on
		queue_sample(32'h5555_5555, 12'sd1, -12'sd1);
		drain();

		// Count above table size saturates; zero velocity, with the pointer toggled off by the first sample
		write_reg(gppr_pkg::REG_MAP_COUNT, 64'd31);
		write_reg(gppr_pkg::REG_VELOCITY, 64'd0);
		write_reg(gppr_pkg::REG_TOGGLE_BTN, 64'd5);
		queue_sample(32'h0000_0020, 12'sd2047, -12'sd2048);
		queue_sample(32'hAAAA_AAAA, -12'sd1, 12'sd1);
		queue_sample(32'h0000_0000, 12'sd0, 12'sd0);
		drain();

		// Empty table, then one past the table size, with the smallest velocity
		write_reg(gppr_pkg::REG_MAP_COUNT, 64'd0);
		write_reg(gppr_pkg::REG_VELOCITY, 64'd1);
		queue_sample(32'hFFFF_FFFF, -12'sd1140, 12'sd1140);
		drain();
		write_reg(gppr_pkg::REG_MAP_COUNT, 64'd17);
		queue_sample(32'hFFFF_FFFF, 12'sd1140, -12'sd1140);
		queue_sample(32'h0000_0000, -12'sd2048, 12'sd2047);
		drain();

		// Random phases: toggle button held in runs so the pointer flips at a
		// realistic rate and stays on long enough to exercise the dot math
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			program_random_setup();
			if (p == 1)
				hold_asks++;
			held = 1'b0;
			for (int k = 0; k < PHASE_SAMPLES; k++) begin
				if ($urandom_range(0, 5) == 0)
					held = !held;
				btn = ($urandom_range(0, 1) != 0) ? $urandom() : ($urandom() & $urandom());
				btn[toggle_btn_r] = held;
				queue_sample(btn, rand_stick(), rand_stick());
			end
			drain();
		end

		// Anything arriving now is a report with no expectation
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/gppr_pkg.sv
rtl/gppr_cfg_regs.sv
rtl/gppr_btn_map.sv
rtl/gppr_ptr_scale.sv
rtl/gamepad_pointer_report_mapper.sv
tb/sv/tb_top.sv
